// ===== hdl/mbr_pkg.sv =====
`timescale 1ns / 1ps

package mbr_pkg;

	// field widths
	localparam int OP_W   = 3;
	localparam int CNT_W  = 14;
	localparam int POS_W  = 13;
	localparam int CUR_W  = 14;
	localparam int LDA_W  = 10;
	localparam int BYTE_W = 8;
	localparam int VAL_W  = 32;
	localparam int BSZ_W  = 11;

	localparam int STORE_BYTES_DEF = 1024;
	localparam int MAX_READ_BITS   = 32;

	localparam logic [BSZ_W-1:0] BSZ_RESET = BSZ_W'(1024);

	// read window: bytes a read may touch, plus one spare
	localparam int WIN_BYTES = (MAX_READ_BITS + 22) / 8;
	localparam int WIN_W     = WIN_BYTES * BYTE_W;
	localparam int NB_W      = $clog2(WIN_BYTES + 1);
	localparam int RC_W      = $clog2(MAX_READ_BITS + 1);

	// operation codes
	localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
	localparam logic [OP_W-1:0] OP_GET    = 3'd1;
	localparam logic [OP_W-1:0] OP_SKIP   = 3'd2;
	localparam logic [OP_W-1:0] OP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_SET    = 3'd4;
	localparam logic [OP_W-1:0] OP_TEST   = 3'd5;
	localparam logic [OP_W-1:0] OP_REWIND = 3'd6;

	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] read_value;
		logic             bit_is_set;
		logic [CUR_W-1:0] position;
		logic [CUR_W-1:0] available;
		logic             status;
	} res_t;

	function automatic logic [CUR_W-1:0] avail_bits(input logic [CUR_W-1:0] tot,
			input logic [CUR_W-1:0] cur);
		return (tot > cur) ? tot - cur : '0;
	endfunction

endpackage

// ===== hdl/msb_first_bit_reader_unit.sv =====
`timescale 1ns / 1ps

// Channel   | Ports                                               | Handshake
// ----------+-----------------------------------------------------+----------------------
// command   | operation bit_count bit_position load_address load_byte | start & !busy
// result    | read_value bit_is_set position available status     | done, one cycle
// config    | buffer_size                                         | buffer_size_we
//
// Cycles: load, skip, back, set, rewind, failed ops and zero-bit reads give
// their result the cycle after acceptance and a new item may follow at once.
// Test bit reads one byte; a read of c bits from bit offset o within a byte
// spans n = ceil((o+c)/8) bytes (up to 5 for 32 bits), fetched one byte per
// cycle through the single byte-wide read port; both hold busy until done.
// Reset: cursor to 0, buffer_size to 1024; byte store contents undefined
// until loaded, no clearing pass.
// Stalls: none from the receiver; each result stands for one cycle only.
module msb_first_bit_reader_unit #(
	parameter int STORE_BYTES = mbr_pkg::STORE_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [mbr_pkg::OP_W-1:0]   operation,
	input  logic [mbr_pkg::CNT_W-1:0]  bit_count,
	input  logic [mbr_pkg::POS_W-1:0]  bit_position,
	input  logic [mbr_pkg::LDA_W-1:0]  load_address,
	input  logic [mbr_pkg::BYTE_W-1:0] load_byte,
	input  logic                       buffer_size_we,
	input  logic [mbr_pkg::BSZ_W-1:0]  buffer_size,
	output logic                       done,
	output logic [mbr_pkg::VAL_W-1:0]  read_value,
	output logic                       bit_is_set,
	output logic [mbr_pkg::CUR_W-1:0]  position,
	output logic [mbr_pkg::CUR_W-1:0]  available,
	output logic                       status
);

	import mbr_pkg::*;

	localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

	logic [BSZ_W-1:0]  buffer_size_q;
	logic [BSZ_W-1:0]  eff_bytes;
	logic [CUR_W-1:0]  total;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;
	res_t              res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= BSZ_RESET;
		end else if (buffer_size_we) begin
			buffer_size_q <= buffer_size;
		end
	end

	// sizes beyond the store act as the full store
	assign eff_bytes = (32'(buffer_size_q) > 32'(STORE_BYTES))
		? BSZ_W'(STORE_BYTES) : buffer_size_q;
	assign total     = {eff_bytes, 3'b000};

	mbr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_BYTES),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mbr_ctrl #(
		.STORE_BYTES (STORE_BYTES),
		.AW          (AW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.bit_count    (bit_count),
		.bit_position (bit_position),
		.load_address (load_address),
		.load_byte    (load_byte),
		.total        (total),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.res          (res)
	);

	assign done       = res.valid;
	assign read_value = res.read_value;
	assign bit_is_set = res.bit_is_set;
	assign position   = res.position;
	assign available  = res.available;
	assign status     = res.status;

endmodule

// ===== hdl/mbr_ram.sv =====
`timescale 1ns / 1ps

module mbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/mbr_ctrl.sv =====
`timescale 1ns / 1ps

module mbr_ctrl #(
	parameter int STORE_BYTES = mbr_pkg::STORE_BYTES_DEF,
	parameter int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [mbr_pkg::OP_W-1:0]    operation,
	input  logic [mbr_pkg::CNT_W-1:0]   bit_count,
	input  logic [mbr_pkg::POS_W-1:0]   bit_position,
	input  logic [mbr_pkg::LDA_W-1:0]   load_address,
	input  logic [mbr_pkg::BYTE_W-1:0]  load_byte,
	input  logic [mbr_pkg::CUR_W-1:0]   total,
	output logic                        ram_we,
	output logic [AW-1:0]               ram_waddr,
	output logic [mbr_pkg::BYTE_W-1:0]  ram_wdata,
	output logic                        ram_re,
	output logic [AW-1:0]               ram_raddr,
	input  logic [mbr_pkg::BYTE_W-1:0]  ram_rdata,
	output mbr_pkg::res_t               res
);

	import mbr_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_FETCH, S_DRAIN} state_t;

	state_t            state_q;
	logic [CUR_W-1:0]  cursor_q;
	logic [AW-1:0]     raddr_q;
	logic [NB_W-1:0]   left_q;
	logic [WIN_W-1:0]  win_q;
	logic [RC_W-1:0]   cnt_q;
	logic [2:0]        sh_q;
	logic [2:0]        tsel_q;
	logic              test_q;
	res_t              res_q;

	logic              accept;
	logic [CUR_W:0]    sum;
	logic [CUR_W:0]    tot_x;
	logic              rd_bad;
	logic              ld_ok;
	logic [AW-1:0]     first_byte;
	logic [NB_W-1:0]   nbytes;
	logic [2:0]        sh;
	logic [CUR_W-1:0]  nxt_cur;
	logic              imm_err;
	logic              go_mem;
	logic              is_test;
	logic              wr;
	logic [WIN_W-1:0]  full;
	logic [VAL_W-1:0]  mask;
	logic [VAL_W-1:0]  val;

	assign accept     = start && (state_q == S_IDLE);
	assign busy       = (state_q != S_IDLE);
	assign sum        = {1'b0, cursor_q} + {1'b0, bit_count};
	assign tot_x      = {1'b0, total};
	assign rd_bad     = (bit_count > CNT_W'(MAX_READ_BITS)) || (sum > tot_x);
	assign ld_ok      = 32'(load_address) < 32'(STORE_BYTES);
	assign first_byte = AW'(cursor_q[CUR_W-1:3]);
	assign nbytes     = NB_W'((8'(cursor_q[2:0]) + 8'(bit_count) + 8'd7) >> 3);
	// last bit read sits this far above bit 0 of the last byte
	assign sh         = 3'd0 - sum[2:0];

	always_comb begin
		nxt_cur = cursor_q;
		imm_err = 1'b0;
		go_mem  = 1'b0;
		is_test = 1'b0;
		wr      = 1'b0;
		unique case (operation)
			OP_LOAD: begin
				wr      = ld_ok;
				imm_err = !ld_ok;
			end
			OP_GET: begin
				if (rd_bad) begin
					imm_err = 1'b1;
				end else begin
					nxt_cur = sum[CUR_W-1:0];
					go_mem  = (bit_count != '0);
				end
			end
			OP_SKIP: begin
				if (sum > tot_x) begin
					nxt_cur = total;
					imm_err = 1'b1;
				end else begin
					nxt_cur = sum[CUR_W-1:0];
				end
			end
			OP_BACK: begin
				if (bit_count > cursor_q) begin
					nxt_cur = '0;
					imm_err = 1'b1;
				end else begin
					nxt_cur = cursor_q - bit_count;
				end
			end
			OP_SET: begin
				if (CUR_W'(bit_position) > total) begin
					nxt_cur = total;
					imm_err = 1'b1;
				end else begin
					nxt_cur = CUR_W'(bit_position);
				end
			end
			OP_TEST: begin
				if (CUR_W'(bit_position) >= total) begin
					imm_err = 1'b1;
				end else begin
					go_mem  = 1'b1;
					is_test = 1'b1;
				end
			end
			OP_REWIND: begin
				nxt_cur = '0;
			end
			default: begin
				imm_err = 1'b1;
			end
		endcase
	end

	assign ram_we    = accept && wr;
	assign ram_waddr = AW'(load_address);
	assign ram_wdata = load_byte;
	assign ram_re    = (accept && go_mem) || (state_q == S_FETCH);
	assign ram_raddr = (state_q == S_IDLE)
		? (is_test ? AW'(bit_position[POS_W-1:3]) : first_byte)
		: raddr_q;

	// extract: last byte straight from the RAM, earlier ones from the window
	assign full = {win_q[WIN_W-BYTE_W-1:0], ram_rdata};
	assign mask = (32'(cnt_q) >= VAL_W) ? '1 : (VAL_W'(1) << cnt_q) - VAL_W'(1);
	assign val  = VAL_W'(full >> sh_q) & mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cursor_q <= '0;
			raddr_q  <= '0;
			left_q   <= '0;
			win_q    <= '0;
			cnt_q    <= '0;
			sh_q     <= '0;
			tsel_q   <= '0;
			test_q   <= 1'b0;
			res_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cursor_q <= nxt_cur;
						if (go_mem) begin
							test_q      <= is_test;
							tsel_q      <= bit_position[2:0];
							sh_q        <= sh;
							cnt_q       <= RC_W'(bit_count);
							raddr_q     <= first_byte + AW'(1);
							left_q      <= nbytes - NB_W'(1);
							state_q     <= (is_test || nbytes == NB_W'(1)) ? S_DRAIN : S_FETCH;
							res_q.valid <= 1'b0;
						end else begin
							res_q <= '{valid: 1'b1, read_value: '0, bit_is_set: 1'b0,
								position: nxt_cur, available: avail_bits(total, nxt_cur),
								status: imm_err};
						end
					end else begin
						res_q.valid <= 1'b0;
					end
				end
				S_FETCH: begin
					win_q       <= {win_q[WIN_W-BYTE_W-1:0], ram_rdata};
					raddr_q     <= raddr_q + AW'(1);
					left_q      <= left_q - NB_W'(1);
					res_q.valid <= 1'b0;
					if (left_q == NB_W'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_IDLE;
					res_q   <= '{valid: 1'b1, read_value: test_q ? '0 : val,
						bit_is_set: test_q & ram_rdata[tsel_q], position: cursor_q,
						available: avail_bits(total, cursor_q), status: 1'b0};
				end
				default: begin
					state_q     <= S_IDLE;
					res_q.valid <= 1'b0;
				end
			endcase
		end
	end

	assign res = res_q;

	a_fetch_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FETCH |-> !res_q.valid)
		else $error("result strobe while fetching");

	a_fetch_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FETCH |-> left_q != '0)
		else $error("fetch with no bytes left");

	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN |=> res_q.valid && state_q == S_IDLE)
		else $error("drain did not deliver a result");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.valid && res_q.status |-> res_q.read_value == '0 && !res_q.bit_is_set)
		else $error("error result carries data");

endmodule

// ===== dv/tb_msb_first_bit_reader_unit.sv =====
`timescale 1ns / 1ps

module tb_msb_first_bit_reader_unit;
	import mbr_pkg::*;

	// operation code that the block does not use: it must answer with an error
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

	localparam int STORE       = STORE_BYTES_DEF;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 75;
	// longest op is a five-byte read; leave some margin when draining
	localparam int DRAIN_CYCLES = 10;
	// ~1000 items with their busy time and random gaps stay well under this limit
	localparam int CYCLE_LIMIT  = 200000;

	typedef enum logic {ROW_ITEM, ROW_SIZE} row_kind_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [CNT_W-1:0]  cnt;
		logic [POS_W-1:0]  pos;
		logic [LDA_W-1:0]  addr;
		logic [BYTE_W-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             bit_set;
		logic [CUR_W-1:0] cur;
		logic [CUR_W-1:0] left;
		logic             err;
	} outcome_t;

	// one line of the directed plan: a command (optionally with its result
	// typed in) or a new buffer size
	typedef struct packed {
		row_kind_t        kind;
		logic [BSZ_W-1:0] size;
		cmd_t             cmd;
		logic             typed;
		outcome_t         want;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [OP_W-1:0]    operation;
	logic [CNT_W-1:0]   bit_count;
	logic [POS_W-1:0]   bit_position;
	logic [LDA_W-1:0]   load_address;
	logic [BYTE_W-1:0]  load_byte;
	logic               buffer_size_we;
	logic [BSZ_W-1:0]   buffer_size;
	logic               done;
	logic [VAL_W-1:0]   read_value;
	logic               bit_is_set;
	logic [CUR_W-1:0]   position;
	logic [CUR_W-1:0]   available;
	logic               status;

	// shadow of the reader: byte store, which bytes hold data, cursor and size
	logic [BYTE_W-1:0]  shadow_bytes [STORE];
	bit                 byte_loaded  [STORE];
	logic [CUR_W-1:0]   shadow_cursor;
	logic [BSZ_W-1:0]   shadow_size;

	outcome_t outcome_q [$];
	row_t     plan_q [$];
	outcome_t due;
	int       mismatches = 0;
	int       cycle_count = 0;
	int       burst_left = 0;

	msb_first_bit_reader_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.bit_count     (bit_count),
		.bit_position  (bit_position),
		.load_address  (load_address),
		.load_byte     (load_byte),
		.buffer_size_we(buffer_size_we),
		.buffer_size   (buffer_size),
		.done          (done),
		.read_value    (read_value),
		.bit_is_set    (bit_is_set),
		.position      (position),
		.available     (available),
		.status        (status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// sizes above the store act as a full store
	function automatic int stream_bits();
		return ((shadow_size > STORE) ? STORE : int'(shadow_size)) * 8;
	endfunction

	// Works out the result of one command and moves the shadow state on.
	// Stream bit k is bit 7-(k%8) of byte k/8; test bit numbers LSB first.
	function automatic outcome_t reader_outcome(input cmd_t c);
		int       total;
		int       cur;
		outcome_t o;
		total = stream_bits();
		cur   = shadow_cursor;
		o     = '0;
		case (c.op)
			OP_LOAD: begin
				shadow_bytes[c.addr] = c.data;
				byte_loaded[c.addr]  = 1'b1;
			end
			OP_GET: begin
				if (c.cnt > MAX_READ_BITS || cur > total || c.cnt > total - cur) begin
					o.err = 1'b1;
				end else begin
					for (int i = 0; i < c.cnt; i++)
						o.value = {o.value[VAL_W-2:0],
							shadow_bytes[(cur + i) / 8][7 - ((cur + i) % 8)]};
					cur += c.cnt;
				end
			end
			OP_SKIP: begin
				if (cur > total || c.cnt > total - cur) begin
					cur   = total;
					o.err = 1'b1;
				end else begin
					cur += c.cnt;
				end
			end
			OP_BACK: begin
				if (c.cnt > cur) begin
					cur   = 0;
					o.err = 1'b1;
				end else begin
					cur -= c.cnt;
				end
			end
			OP_SET: begin
				if (c.pos > total) begin
					cur   = total;
					o.err = 1'b1;
				end else begin
					cur = c.pos;
				end
			end
			OP_TEST: begin
				if (c.pos >= total)
					o.err = 1'b1;
				else
					o.bit_set = shadow_bytes[c.pos / 8][c.pos % 8];
			end
			OP_REWIND: cur = 0;
			default:   o.err = 1'b1;
		endcase
		o.cur         = CUR_W'(cur);
		o.left        = (total > cur) ? CUR_W'(total - cur) : '0;
		shadow_cursor = CUR_W'(cur);
		return o;
	endfunction

	// directed plan builders
	function automatic void row_cmd(input logic [OP_W-1:0] op, input int cnt, input int pos,
			input int addr, input int data);
		row_t r;
		r       = '0;
		r.kind  = ROW_ITEM;
		r.cmd   = '{op, CNT_W'(cnt), POS_W'(pos), LDA_W'(addr), BYTE_W'(data)};
		plan_q.push_back(r);
	endfunction

	function automatic void row_chk(input logic [OP_W-1:0] op, input int cnt, input int pos,
			input int addr, input int data, input logic [VAL_W-1:0] value,
			input logic bit_set, input int cur, input int left, input logic err);
		row_t r;
		r       = '0;
		r.kind  = ROW_ITEM;
		r.cmd   = '{op, CNT_W'(cnt), POS_W'(pos), LDA_W'(addr), BYTE_W'(data)};
		r.typed = 1'b1;
		r.want  = '{value, bit_set, CUR_W'(cur), CUR_W'(left), err};
		plan_q.push_back(r);
	endfunction

	function automatic void row_size(input int size);
		row_t r;
		r      = '0;
		r.kind = ROW_SIZE;
		r.size = BSZ_W'(size);
		plan_q.push_back(r);
	endfunction

	// Presents one item, holding start until it is taken. Items go out in
	// bursts; between bursts start may drop for a random number of cycles.
	task automatic send(input cmd_t c, input logic typed, input outcome_t want);
		int       gap;
		outcome_t got;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				@(negedge clk);
				start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		@(negedge clk);
		start        <= 1'b1;
		operation    <= c.op;
		bit_count    <= c.cnt;
		bit_position <= c.pos;
		load_address <= c.addr;
		load_byte    <= c.data;
		do @(posedge clk); while (busy);
		// taken at this edge
		got = reader_outcome(c);
		outcome_q.push_back(typed ? want : got);
	endtask

	// loads a random value into a byte that a read or test is about to touch
	task automatic fill_byte(input int b);
		cmd_t c;
		c.op   = OP_LOAD;
		c.cnt  = CNT_W'($urandom_range(0, 16383));
		c.pos  = POS_W'($urandom_range(0, 8191));
		c.addr = LDA_W'(b);
		c.data = BYTE_W'($urandom_range(0, 255));
		send(c, 1'b0, '0);
	endtask

	// buffer_size is only touched with the reader idle and nothing in flight
	task automatic write_size(input logic [BSZ_W-1:0] size);
		@(negedge clk);
		start <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		buffer_size_we <= 1'b1;
		buffer_size    <= size;
		@(negedge clk);
		buffer_size_we <= 1'b0;
		shadow_size = size;
		burst_left  = 0;
	endtask

	// results: each strobe is checked against the oldest pending outcome
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				$error("result strobe with no item pending");
				mismatches++;
			end else begin
				due = outcome_q.pop_front();
				if (read_value !== due.value) begin
					$error("read_value: expected %h, got %h", due.value, read_value);
					mismatches++;
				end
				if (bit_is_set !== due.bit_set) begin
					$error("bit_is_set: expected %0d, got %0d", due.bit_set, bit_is_set);
					mismatches++;
				end
				if (position !== due.cur) begin
					$error("position: expected %0d, got %0d", due.cur, position);
					mismatches++;
				end
				if (available !== due.left) begin
					$error("available: expected %0d, got %0d", due.left, available);
					mismatches++;
				end
				if (status !== due.err) begin
					$error("status: expected %0d, got %0d", due.err, status);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		cmd_t c;
		row_t row;
		int   r;
		int   total;
		int   phase;
		int   sent;
		int   phase_sizes [PHASES];

		start          = 1'b0;
		operation      = '0;
		bit_count      = '0;
		bit_position   = '0;
		load_address   = '0;
		load_byte      = '0;
		buffer_size_we = 1'b0;
		buffer_size    = '0;
		arst_n         = 1'b0;
		shadow_cursor  = '0;
		shadow_size    = BSZ_RESET;
		foreach (byte_loaded[i])
			byte_loaded[i] = 1'b0;

		// --- directed plan ---
		// zero-bit read straight out of reset
		row_chk(OP_GET, 0, 0, 0, 0, 32'h0, 1'b0, 0, 8192, 1'b0);
		row_chk(OP_LOAD, 0, 0, 0, 8'hff, 32'h0, 1'b0, 0, 8192, 1'b0);
		row_cmd(OP_LOAD, 0, 0, 1, 8'h00);
		row_cmd(OP_LOAD, 0, 0, 2, 8'ha5);
		row_cmd(OP_LOAD, 0, 0, 3, 8'h3c);
		row_cmd(OP_LOAD, 0, 0, 4, 8'h81);
		row_cmd(OP_LOAD, 0, 0, 1023, 8'h80);
		// one bit too many: refused, cursor kept
		row_chk(OP_GET, 33, 0, 0, 0, 32'h0, 1'b0, 0, 8192, 1'b1);
		// full-width read, byte aligned
		row_chk(OP_GET, 32, 0, 0, 0, 32'hff00a53c, 1'b0, 32, 8160, 1'b0);
		row_cmd(OP_BACK, 28, 0, 0, 0);
		// full width from a nibble offset: spans five bytes
		row_cmd(OP_GET, 32, 0, 0, 0);
		row_cmd(OP_TEST, 0, 0, 0, 0);
		row_cmd(OP_TEST, 0, 8191, 0, 0);
		// skip past end clamps; read at end fails
		row_chk(OP_SKIP, 8192, 0, 0, 0, 32'h0, 1'b0, 8192, 0, 1'b1);
		row_chk(OP_GET, 1, 0, 0, 0, 32'h0, 1'b0, 8192, 0, 1'b1);
		// back before start clamps to zero
		row_chk(OP_BACK, 16383, 0, 0, 0, 32'h0, 1'b0, 0, 8192, 1'b1);
		row_chk(OP_SET, 0, 8191, 0, 0, 32'h0, 1'b0, 8191, 1, 1'b0);
		row_cmd(OP_GET, 1, 0, 0, 0);
		row_chk(OP_REWIND, 0, 0, 0, 0, 32'h0, 1'b0, 0, 8192, 1'b0);
		row_chk(OP_UNUSED, 16383, 8191, 1023, 8'hff, 32'h0, 1'b0, 0, 8192, 1'b1);
		row_chk(OP_SET, 0, 100, 0, 0, 32'h0, 1'b0, 100, 8092, 1'b0);
		// shrink below the cursor: nothing left, reads refused
		row_size(2);
		row_chk(OP_GET, 1, 0, 0, 0, 32'h0, 1'b0, 100, 0, 1'b1);
		row_cmd(OP_TEST, 0, 15, 0, 0);
		row_chk(OP_SET, 0, 17, 0, 0, 32'h0, 1'b0, 16, 0, 1'b1);
		// empty stream
		row_size(0);
		row_chk(OP_TEST, 0, 0, 0, 0, 32'h0, 1'b0, 16, 0, 1'b1);
		row_chk(OP_SKIP, 0, 0, 0, 0, 32'h0, 1'b0, 0, 0, 1'b1);
		// oversize acts as the full store
		row_size(2047);
		row_cmd(OP_SKIP, 5, 0, 0, 0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan_q[i]) begin
			row = plan_q[i];
			if (row.kind == ROW_SIZE)
				write_size(row.size);
			else
				send(row.cmd, row.typed, row.want);
		end

		// --- random phases, one buffer size each ---
		phase_sizes = '{1, 1024, 3, 2047, 0, 9, 1024, 2, 512, 1024};
		phase_sizes[8] = $urandom_range(1, STORE);
		for (phase = 0; phase < PHASES; phase++) begin
			write_size(BSZ_W'(phase_sizes[phase]));
			for (sent = 0; sent < PHASE_ITEMS; sent++) begin
				total  = stream_bits();
				c.cnt  = CNT_W'($urandom_range(0, 16383));
				c.pos  = POS_W'($urandom_range(0, 8191));
				c.addr = LDA_W'($urandom_range(0, STORE - 1));
				c.data = BYTE_W'($urandom_range(0, 255));
				r      = $urandom_range(0, 99);
				if (r < 18) begin
					c.op = OP_LOAD;
					// keep the bytes around the cursor populated
					if ($urandom_range(0, 1))
						c.addr = LDA_W'((shadow_cursor / 8 + $urandom_range(0, 5)) % STORE);
				end else if (r < 50) begin
					c.op = OP_GET;
					if ($urandom_range(0, 9) != 0)
						c.cnt = CNT_W'($urandom_range(0, MAX_READ_BITS));
					else if ($urandom_range(0, 1))
						c.cnt = CNT_W'(MAX_READ_BITS + 1);
				end else if (r < 60) begin
					c.op = OP_SKIP;
					if ($urandom_range(0, 3) != 0)
						c.cnt = CNT_W'($urandom_range(0, 40));
				end else if (r < 70) begin
					c.op = OP_BACK;
					if ($urandom_range(0, 3) != 0)
						c.cnt = CNT_W'($urandom_range(0, 40));
				end else if (r < 80) begin
					c.op = OP_SET;
					case ($urandom_range(0, 3))
						0: ;
						1: c.pos = POS_W'(((total > 8191) ? 8191 : total)
							- $urandom_range(0, (total > 40) ? 40 : total));
						default: c.pos = POS_W'($urandom_range(0, (total > 8191) ? 8191 : total));
					endcase
				end else if (r < 92) begin
					c.op = OP_TEST;
					if ($urandom_range(0, 3) != 0 && total > 0)
						c.pos = POS_W'($urandom_range(0, total - 1));
				end else if (r < 96) begin
					c.op = OP_REWIND;
				end else begin
					c.op = OP_UNUSED;
				end

				// never let a read or test touch a byte that holds no data yet
				if (c.op == OP_GET && c.cnt != 0 && c.cnt <= MAX_READ_BITS
						&& shadow_cursor <= total && c.cnt <= total - shadow_cursor) begin
					for (int b = shadow_cursor / 8; b <= (shadow_cursor + c.cnt - 1) / 8; b++)
						if (!byte_loaded[b])
							fill_byte(b);
				end
				if (c.op == OP_TEST && c.pos < total && !byte_loaded[c.pos / 8])
					fill_byte(c.pos / 8);

				send(c, 1'b0, '0);
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/mbr_pkg.sv
hdl/mbr_ram.sv
hdl/mbr_ctrl.sv
hdl/msb_first_bit_reader_unit.sv
dv/tb_msb_first_bit_reader_unit.sv
